FILE: hdl/brf_pkg.sv
// Shared types, constants and slot-mapping functions for the banked register file.
package brf_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned VecW      = 5;
  localparam int unsigned ModeW     = 5;
  localparam int unsigned NumUser   = 16;
  localparam int unsigned NumFiq    = 7;
  localparam int unsigned NumPair   = 8;
  localparam int unsigned NumPhys   = NumUser + NumFiq + NumPair;
  localparam int unsigned SlotW     = $clog2(NumPhys);
  localparam int unsigned NumSaved  = 5;
  localparam int unsigned SavedIdxW = $clog2(NumSaved);

  localparam logic [SlotW-1:0] FiqBase  = SlotW'(NumUser);
  localparam logic [SlotW-1:0] PairBase = SlotW'(NumUser + NumFiq);
  localparam logic [SlotW-1:0] PcSlot   = SlotW'(15);

  localparam logic [IdxW-1:0] RegFirstBanked = IdxW'(8);
  localparam logic [IdxW-1:0] RegFirstPair   = IdxW'(13);
  localparam logic [IdxW-1:0] RegLink        = IdxW'(14);

  localparam logic [DataW-1:0] StatusReset = 32'h0000_00D3;
  localparam logic [DataW-1:0] PcReset     = 32'h0000_0004;
  localparam logic [DataW-1:0] IrqMask     = 32'h0000_0080;
  localparam logic [DataW-1:0] ModeClear   = 32'h0000_003F;
  localparam logic [DataW-1:0] ThumbBit    = 32'h0000_0020;
  localparam logic [DataW-1:0] PcOffset    = 32'h0000_0004;
  localparam logic [ModeW-1:0] ModeMask    = 5'h1F;

  localparam logic [ModeW-1:0] ModeUsr = 5'h10;
  localparam logic [ModeW-1:0] ModeFiq = 5'h11;
  localparam logic [ModeW-1:0] ModeIrq = 5'h12;
  localparam logic [ModeW-1:0] ModeSvc = 5'h13;
  localparam logic [ModeW-1:0] ModeAbt = 5'h17;
  localparam logic [ModeW-1:0] ModeUnd = 5'h1B;
  localparam logic [ModeW-1:0] ModeSys = 5'h1F;

  typedef enum logic [1:0] {
    KindRead   = 2'd0,
    KindWrite  = 2'd1,
    KindStatus = 2'd2,
    KindExc    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    BankUsr = 3'd0,
    BankFiq = 3'd1,
    BankIrq = 3'd2,
    BankSvc = 3'd3,
    BankAbt = 3'd4,
    BankUnd = 3'd5
  } bank_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StLink,
    StResp
  } state_e;

  typedef struct packed {
    logic take;
    logic exec;
    logic link;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_exc;
  } sts_t;

  function automatic logic [ModeW-1:0] vector_mode(input logic [2:0] sel);
    logic [ModeW-1:0] mode;
    unique case (sel)
      3'd0:    mode = ModeSvc;
      3'd1:    mode = ModeUnd;
      3'd2:    mode = ModeSvc;
      3'd3:    mode = ModeAbt;
      3'd4:    mode = ModeAbt;
      3'd5:    mode = ModeSvc;
      3'd6:    mode = ModeIrq;
      default: mode = ModeFiq;
    endcase
    return mode;
  endfunction

  function automatic bank_e mode_bank(input logic [ModeW-1:0] mode, input bank_e cur);
    bank_e bank;
    unique case (mode)
      ModeUsr, ModeSys: bank = BankUsr;
      ModeFiq:          bank = BankFiq;
      ModeIrq:          bank = BankIrq;
      ModeSvc:          bank = BankSvc;
      ModeAbt:          bank = BankAbt;
      ModeUnd:          bank = BankUnd;
      default:          bank = cur;
    endcase
    return bank;
  endfunction

  function automatic logic has_saved(input bank_e bank);
    logic [2:0] b;
    b = bank;
    return (b >= 3'(BankFiq)) && (b <= 3'(BankUnd));
  endfunction

  function automatic logic [SavedIdxW-1:0] saved_idx(input bank_e bank);
    logic [2:0] b;
    b = bank;
    return SavedIdxW'(b - 3'(BankFiq));
  endfunction

  function automatic logic [SlotW-1:0] reg_slot(input logic [IdxW-1:0] idx, input bank_e bank);
    logic [2:0]       b;
    logic [2:0]       off;
    logic [2:0]       pair;
    logic [SlotW-1:0] slot;
    b    = bank;
    off  = b - 3'(BankIrq);
    pair = {off[1:0], ~idx[0]};
    slot = {1'b0, idx[3:0]};
    if (idx >= RegFirstBanked && idx <= RegLink) begin
      if (bank == BankFiq) begin
        slot = FiqBase + (idx - RegFirstBanked);
      end else if (idx >= RegFirstPair && b >= 3'(BankIrq) && b <= 3'(BankUnd)) begin
        slot = PairBase + SlotW'(pair);
      end
    end
    return slot;
  endfunction

endpackage

FILE: hdl/brf_if.sv
// Request and response channel interfaces of the banked register file.
interface brf_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [brf_pkg::IdxW-1:0]       reg_index;
  logic [brf_pkg::DataW-1:0]      data_value;
  logic                           save_old;
  logic [brf_pkg::VecW-1:0]       vector;

  modport source (output valid, kind, reg_index, data_value, save_old, vector, input ready);
  modport sink   (input valid, kind, reg_index, data_value, save_old, vector, output ready);
endinterface

interface brf_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [brf_pkg::DataW-1:0] read_value;
  logic [brf_pkg::DataW-1:0] status_out;
  logic [brf_pkg::DataW-1:0] saved_status_out;
  logic                      saved_present;

  modport source (output valid, read_value, status_out, saved_status_out, saved_present,
                  input ready);
  modport sink   (input valid, read_value, status_out, saved_status_out, saved_present,
                  output ready);
endinterface

FILE: hdl/banked_register_file_mode_switch.sv
// Top level of the banked register file with status word and exception entry.
//
//   channel  dir  payload                                              accepted on
//   req_i    in   kind, reg_index, data_value, save_old, vector        valid & ready
//   rsp_o    out  read_value, status_out, saved_status_out,            valid & ready
//                 saved_present
//
// One request at a time: read, write and status requests step through accept,
// execute and load result; exception entry adds a link step after execute that
// writes the link register and the PC together in the register array.
// A request is taken again once its result sits in the output register.
// Reset clears all registers to zero, PC to 4, status to 0xD3, supervisor bank.
// A stalled response holds the sequencer in its result step.
module banked_register_file_mode_switch (
  input  logic      clk_i,
  input  logic      rst_ni,
  brf_req_if.sink   req_i,
  brf_rsp_if.source rsp_o
);

  brf_pkg::cmd_t cmd;
  brf_pkg::sts_t sts;

  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .kind_i             (req_i.kind),
    .reg_index_i        (req_i.reg_index),
    .data_value_i       (req_i.data_value),
    .save_old_i         (req_i.save_old),
    .vector_i           (req_i.vector),
    .read_value_o       (rsp_o.read_value),
    .status_out_o       (rsp_o.status_out),
    .saved_status_out_o (rsp_o.saved_status_out),
    .saved_present_o    (rsp_o.saved_present)
  );

endmodule

FILE: hdl/brf_ctrl.sv
// Sequencing state machine of the banked register file.
module brf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  brf_pkg::sts_t sts_i,
  output brf_pkg::cmd_t cmd_o
);

  brf_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brf_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      brf_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = brf_pkg::StExec;
        end
      end
      brf_pkg::StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_exc ? brf_pkg::StLink : brf_pkg::StResp;
      end
      brf_pkg::StLink: begin
        cmd_o.link = 1'b1;
        state_d    = brf_pkg::StResp;
      end
      brf_pkg::StResp: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = brf_pkg::StIdle;
        end
      end
      default: state_d = brf_pkg::StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/brf_dp.sv
// Register banks, status words and result register of the banked register file.
module brf_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brf_pkg::cmd_t              cmd_i,
  output brf_pkg::sts_t              sts_o,
  input  logic [1:0]                 kind_i,
  input  logic [brf_pkg::IdxW-1:0]   reg_index_i,
  input  logic [brf_pkg::DataW-1:0]  data_value_i,
  input  logic                       save_old_i,
  input  logic [brf_pkg::VecW-1:0]   vector_i,
  output logic [brf_pkg::DataW-1:0]  read_value_o,
  output logic [brf_pkg::DataW-1:0]  status_out_o,
  output logic [brf_pkg::DataW-1:0]  saved_status_out_o,
  output logic                       saved_present_o
);

  brf_pkg::kind_e                kind_q;
  logic [brf_pkg::IdxW-1:0]      idx_q;
  logic [brf_pkg::DataW-1:0]     data_q;
  logic                          save_q;
  logic [brf_pkg::VecW-1:0]      vec_q;

  logic [brf_pkg::DataW-1:0]     regs_q [brf_pkg::NumPhys];
  logic [brf_pkg::DataW-1:0]     spsr_q [brf_pkg::NumSaved];
  logic [brf_pkg::DataW-1:0]     cpsr_q;
  brf_pkg::bank_e                bank_q;

  logic [brf_pkg::DataW-1:0]     read_q, status_q, saved_q;
  logic                          present_q;

  logic [brf_pkg::DataW-1:0]     load_val;
  logic                          load_save;
  logic                          load_en;
  brf_pkg::bank_e                new_bank;
  logic [brf_pkg::SlotW-1:0]     acc_slot;
  logic [brf_pkg::SlotW-1:0]     link_slot;
  logic                          thumb;
  logic [brf_pkg::DataW-1:0]     link_val;
  logic [brf_pkg::DataW-1:0]     pc_val;
  logic [brf_pkg::DataW-1:0]     cur_saved;

  always_comb begin
    if (kind_q == brf_pkg::KindExc) begin
      load_val = (cpsr_q & ~brf_pkg::ModeClear) | brf_pkg::IrqMask
               | brf_pkg::DataW'(brf_pkg::vector_mode(vec_q[4:2]));
    end else begin
      load_val = data_q;
    end
    load_save = (kind_q == brf_pkg::KindExc) || save_q;
    load_en   = cmd_i.exec && ((kind_q == brf_pkg::KindStatus) || (kind_q == brf_pkg::KindExc));
    if ((load_val[brf_pkg::ModeW-1:0] & brf_pkg::ModeMask)
        != (cpsr_q[brf_pkg::ModeW-1:0] & brf_pkg::ModeMask)) begin
      new_bank = brf_pkg::mode_bank(load_val[brf_pkg::ModeW-1:0], bank_q);
    end else begin
      new_bank = bank_q;
    end
  end

  assign acc_slot  = brf_pkg::reg_slot(idx_q, bank_q);
  assign link_slot = brf_pkg::reg_slot(brf_pkg::RegLink, bank_q);
  assign cur_saved = brf_pkg::has_saved(bank_q) ? spsr_q[brf_pkg::saved_idx(bank_q)] : '0;
  assign thumb     = (cur_saved & brf_pkg::ThumbBit) != '0;
  assign link_val  = regs_q[brf_pkg::PcSlot] + brf_pkg::DataW'({thumb, 1'b0});
  assign pc_val    = brf_pkg::DataW'({vec_q[4:2], 2'b00}) + brf_pkg::PcOffset;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= brf_pkg::kind_e'(kind_i);
      idx_q  <= reg_index_i;
      data_q <= data_value_i;
      save_q <= save_old_i;
      vec_q  <= vector_i;
    end
    if (cmd_i.load_out) begin
      read_q    <= regs_q[acc_slot];
      status_q  <= cpsr_q;
      saved_q   <= cur_saved;
      present_q <= brf_pkg::has_saved(bank_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < brf_pkg::NumPhys; i++) begin
        regs_q[i] <= (i == int'(brf_pkg::PcSlot)) ? brf_pkg::PcReset : '0;
      end
      for (int i = 0; i < brf_pkg::NumSaved; i++) begin
        spsr_q[i] <= '0;
      end
      cpsr_q <= brf_pkg::StatusReset;
      bank_q <= brf_pkg::BankSvc;
    end else begin
      if (cmd_i.exec && kind_q == brf_pkg::KindWrite) begin
        regs_q[acc_slot] <= data_q;
      end
      if (cmd_i.link) begin
        regs_q[link_slot]       <= link_val;
        regs_q[brf_pkg::PcSlot] <= pc_val;
      end
      if (load_en) begin
        bank_q <= new_bank;
        cpsr_q <= load_val;
        if (load_save && brf_pkg::has_saved(new_bank)) begin
          spsr_q[brf_pkg::saved_idx(new_bank)] <= cpsr_q;
        end
      end
    end
  end

  assign sts_o.is_exc       = (kind_q == brf_pkg::KindExc);
  assign read_value_o       = read_q;
  assign status_out_o       = status_q;
  assign saved_status_out_o = saved_q;
  assign saved_present_o    = present_q;

endmodule

FILE: tb/sv/banked_register_file_mode_switch_tb.sv
// Self-checking testbench: directed and random requests against a banked register file predictor.
module banked_register_file_mode_switch_tb;
  import brf_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] rd;
    logic [DataW-1:0] st;
    logic [DataW-1:0] sv;
    logic             pres;
  } reg_view_t;

  typedef struct packed {
    kind_e            kind;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
    logic             save;
    logic [VecW-1:0]  vec;
    logic             typed;
    reg_view_t        view;
  } stim_row_t;

  localparam logic [IdxW-1:0] RegPc = IdxW'(15);
  localparam int unsigned FiqAt  = NumUser;
  localparam int unsigned PairAt = NumUser + NumFiq;
  localparam logic [7:0][ModeW-1:0] ExcModeTable =
    {ModeFiq, ModeIrq, ModeSvc, ModeAbt, ModeAbt, ModeSvc, ModeUnd, ModeSvc};
  localparam int unsigned HoldCycles = 300;

  logic clk_i;
  logic rst_ni;

  brf_req_if req_if ();
  brf_rsp_if rsp_if ();

  banked_register_file_mode_switch u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic [DataW-1:0] regs_q [NumPhys];
  logic [DataW-1:0] spsr_q [NumSaved];
  logic [DataW-1:0] cpsr_q;
  bank_e            bank_q;

  reg_view_t   views_due [$];
  stim_row_t   stim_rows [$];
  logic        row_typed;
  reg_view_t   row_view;
  int unsigned mismatches;
  int unsigned send_idle;
  int unsigned rcv_idle;
  bit          hold_req;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic int unsigned reg_loc(logic [IdxW-1:0] idx);
    if (idx >= RegFirstBanked && idx <= RegLink) begin
      if (bank_q == BankFiq) begin
        return FiqAt + int'(idx - RegFirstBanked);
      end
      if (idx >= RegFirstPair && bank_q >= BankIrq && bank_q <= BankUnd) begin
        return PairAt + 2 * (int'(bank_q) - int'(BankIrq)) + int'(idx - RegFirstPair);
      end
    end
    return int'(idx[3:0]);
  endfunction

  function automatic void load_status(logic [DataW-1:0] value, logic keep_old);
    if (value[ModeW-1:0] != cpsr_q[ModeW-1:0]) begin
      case (value[ModeW-1:0])
        ModeUsr, ModeSys: bank_q = BankUsr;
        ModeFiq:          bank_q = BankFiq;
        ModeIrq:          bank_q = BankIrq;
        ModeSvc:          bank_q = BankSvc;
        ModeAbt:          bank_q = BankAbt;
        ModeUnd:          bank_q = BankUnd;
        default:          ;
      endcase
    end
    if (keep_old && bank_q != BankUsr) begin
      spsr_q[int'(bank_q) - int'(BankFiq)] = cpsr_q;
    end
    cpsr_q = value;
  endfunction

  function automatic reg_view_t execute_request(kind_e k, logic [IdxW-1:0] idx,
                                                logic [DataW-1:0] d, logic s,
                                                logic [VecW-1:0] v);
    reg_view_t        view;
    logic [DataW-1:0] link_adj;
    case (k)
      KindWrite:  regs_q[reg_loc(idx)] = d;
      KindStatus: load_status(d, s);
      KindExc: begin
        load_status((cpsr_q & ~ModeClear) | IrqMask | DataW'(ExcModeTable[v[4:2]]), 1'b1);
        link_adj = '0;
        if (bank_q != BankUsr) begin
          if ((spsr_q[int'(bank_q) - int'(BankFiq)] & ThumbBit) != '0) link_adj = 32'd2;
        end
        regs_q[reg_loc(RegLink)] = regs_q[RegPc] + link_adj;
        regs_q[RegPc] = DataW'({v[4:2], 2'b00}) + PcOffset;
      end
      default: ;
    endcase
    view.rd   = regs_q[reg_loc(idx)];
    view.st   = cpsr_q;
    view.pres = (bank_q != BankUsr);
    view.sv   = view.pres ? spsr_q[int'(bank_q) - int'(BankFiq)] : '0;
    return view;
  endfunction

  task automatic report_mismatch(string field, logic [DataW-1:0] got, logic [DataW-1:0] want);
    $display("mismatch on %s: got %h, want %h", field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : monitor
    reg_view_t got;
    reg_view_t want;
    if (rst_ni && req_if.valid && req_if.ready) begin
      want = execute_request(kind_e'(req_if.kind), req_if.reg_index, req_if.data_value,
                             req_if.save_old, req_if.vector);
      if (row_typed) want = row_view;
      views_due.push_back(want);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.read_value, rsp_if.status_out, rsp_if.saved_status_out,
              rsp_if.saved_present};
      if (views_due.size() == 0) begin
        report_mismatch("unrequested response", got.rd, '0);
      end else begin
        want = views_due.pop_front();
        if (got.rd !== want.rd) report_mismatch("read_value", got.rd, want.rd);
        if (got.st !== want.st) report_mismatch("status_out", got.st, want.st);
        if (got.sv !== want.sv) report_mismatch("saved_status_out", got.sv, want.sv);
        if (got.pres !== want.pres) report_mismatch("saved_present", got.pres, want.pres);
      end
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        // hold off the responses so the request side backs up
        repeat (HoldCycles) begin
          rsp_if.ready <= 1'b0;
          @(negedge clk_i);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic offer(kind_e k, logic [IdxW-1:0] idx, logic [DataW-1:0] d, logic s,
                       logic [VecW-1:0] v, logic typed, reg_view_t tv);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= k;
    req_if.reg_index  <= idx;
    req_if.data_value <= d;
    req_if.save_old   <= s;
    req_if.vector     <= v;
    row_typed         <= typed;
    row_view          <= tv;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic add_row(kind_e k, logic [IdxW-1:0] idx, logic [DataW-1:0] d, logic s,
                         logic [VecW-1:0] v, logic typed, reg_view_t tv);
    stim_rows.push_back('{k, idx, d, s, v, typed, tv});
  endtask

  task automatic offer_random();
    kind_e            k;
    logic [DataW-1:0] d;
    int unsigned      pick;
    pick = $urandom_range(99);
    d    = $urandom;
    if (pick < 30) begin
      k = KindRead;
    end else if (pick < 65) begin
      k = KindWrite;
      case ($urandom_range(9))
        0:       d = '0;
        1:       d = '1;
        default: ;
      endcase
    end else if (pick < 85) begin
      k = KindStatus;
      if ($urandom_range(9) >= 3) begin
        case ($urandom_range(6))
          0:       d[ModeW-1:0] = ModeUsr;
          1:       d[ModeW-1:0] = ModeFiq;
          2:       d[ModeW-1:0] = ModeIrq;
          3:       d[ModeW-1:0] = ModeSvc;
          4:       d[ModeW-1:0] = ModeAbt;
          5:       d[ModeW-1:0] = ModeUnd;
          default: d[ModeW-1:0] = ModeSys;
        endcase
      end
    end else begin
      k = KindExc;
    end
    offer(k, IdxW'($urandom_range(31)), d, 1'($urandom_range(1)),
          VecW'($urandom_range(31)), 1'b0, '0);
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = KindRead;
    req_if.reg_index  = '0;
    req_if.data_value = '0;
    req_if.save_old   = 1'b0;
    req_if.vector     = '0;
    row_typed         = 1'b0;
    row_view          = '0;
    mismatches        = 0;
    hold_req          = 1'b0;
    send_idle         = 8;
    rcv_idle          = 81;
    foreach (regs_q[i]) regs_q[i] = '0;
    foreach (spsr_q[i]) spsr_q[i] = '0;
    regs_q[RegPc] = PcReset;
    cpsr_q        = StatusReset;
    bank_q        = BankSvc;

    add_row(KindRead,   15, '0,           0, 0,  1, '{PcReset, StatusReset, '0, 1'b1});
    add_row(KindWrite,  0,  '1,           0, 0,  1, '{'1, StatusReset, '0, 1'b1});
    add_row(KindRead,   16, '0,           0, 0,  1, '{'1, StatusReset, '0, 1'b1});
    add_row(KindWrite,  13, 32'h1234_5678, 0, 0, 0, '0);
    add_row(KindWrite,  8,  32'hA5A5_A5A5, 0, 0, 0, '0);
    add_row(KindWrite,  31, '1,           0, 0,  0, '0);
    add_row(KindStatus, 13, 32'h10,       1, 0,  1, '{'0, 32'h10, '0, 1'b0});
    add_row(KindStatus, 8,  32'hD1,       1, 0,  0, '0);
    add_row(KindWrite,  14, 32'h0F0F_0F0F, 0, 0, 0, '0);
    add_row(KindStatus, 14, 32'h05,       1, 0,  0, '0);
    add_row(KindStatus, 13, 32'h12,       0, 0,  0, '0);
    add_row(KindStatus, 14, 32'h17,       1, 0,  0, '0);
    add_row(KindStatus, 13, 32'h1B,       1, 0,  0, '0);
    add_row(KindStatus, 15, '1,           1, 0,  0, '0);
    add_row(KindExc,    14, '0,           0, 31, 0, '0);
    add_row(KindExc,    15, '0,           0, 0,  0, '0);
    add_row(KindExc,    14, '0,           0, 4,  0, '0);
    add_row(KindExc,    13, '0,           0, 8,  0, '0);
    add_row(KindExc,    14, '0,           0, 12, 0, '0);
    add_row(KindExc,    14, '0,           0, 16, 0, '0);
    add_row(KindExc,    15, '0,           0, 20, 0, '0);
    add_row(KindExc,    13, '0,           0, 24, 0, '0);
    add_row(KindExc,    9,  '0,           0, 28, 0, '0);
    add_row(KindStatus, 14, 32'h33,       1, 0,  0, '0);
    add_row(KindExc,    14, '0,           0, 3,  0, '0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      offer(stim_rows[i].kind, stim_rows[i].idx, stim_rows[i].data, stim_rows[i].save,
            stim_rows[i].vec, stim_rows[i].typed, stim_rows[i].view);
    end
    repeat (160) offer_random();

    send_idle = 81;
    rcv_idle  = 8;
    repeat (170) offer_random();

    send_idle = 0;
    rcv_idle  = 0;
    hold_req  = 1'b1;
    repeat (170) offer_random();
    req_if.valid <= 1'b0;
    row_typed    <= 1'b0;

    while (views_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
